// ===== rtl/core/fcal_pkg.sv =====
package fcal_pkg;

    // Default sizing of the link table.
    localparam int NUM_BLOCKS_DEF  = 1024;
    localparam int BLOCK_BYTES_DEF = 512;

    // Field widths of the two channels.
    localparam int KIND_W   = 2;
    localparam int START_W  = 10;
    localparam int SIZE_W   = 20;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;
    localparam int TOUCH_W  = 11;
    localparam int FREE_W   = 11;

    // Byte coverage of a chain under construction; one bit over the size field
    // leaves room for a whole block beyond the largest size.
    localparam int COV_W = SIZE_W + 1;

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXTEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_TERM   = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_EXT_CHK,
        S_EXT_SCAN,
        S_TERM_CHK,
        S_TERM_SCAN,
        S_TERM_LINK,
        S_TERM_END,
        S_FREE_WALK,
        S_RESP
    } fcal_state_t;

endpackage

// ===== rtl/core/fcal_link_mem.sv =====
module fcal_link_mem #(
    parameter int DEPTH  = fcal_pkg::NUM_BLOCKS_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = $clog2(DEPTH) + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    import fcal_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;

    // Storage array with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg        <= mem[raddr];
            fwd_data_reg <= wdata;
        end
    end

    // A read that meets a write to the same entry returns the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (re)
        begin
            fwd_hit_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = fwd_hit_reg ? fwd_data_reg : q_reg;

endmodule

// ===== rtl/core/fat_chain_allocator.sv =====
// Block chain allocator over a link table of NUM_BLOCKS entries.
// Input channel (in_valid/in_ready) carries one request: kind, chain_start and
// size_bytes. Output channel (out_valid/out_ready) returns exactly one result
// per request: status, block_index, blocks_touched and free_left.
// One request is worked on at a time; in_ready is high only while the
// sequencer is idle. The link table sits in a synchronous memory with one
// write and one read port, so each step does at most one read and one write.
// Allocate scans first-fit. Free walks the chain one block per cycle.
// Extend scans for further blocks and then rescans for the terminator.
// The sequencer returns to idle, raising in_ready, in the same cycle that
// out_valid rises. After reset the block clears the table to free, one
// entry per cycle, with in_ready low; the free counter starts full.
// The result sits in an output register; a stalled receiver holds the
// sequencer in its response step until the previous result has been taken,
// after which the next request is accepted while the new result waits.
module fat_chain_allocator #(
    parameter int NUM_BLOCKS  = fcal_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = fcal_pkg::BLOCK_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fcal_pkg::KIND_W-1:0]   kind,
    input  logic [fcal_pkg::START_W-1:0]  chain_start,
    input  logic [fcal_pkg::SIZE_W-1:0]   size_bytes,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fcal_pkg::STATUS_W-1:0] status,
    output logic [fcal_pkg::INDEX_W-1:0]  block_index,
    output logic [fcal_pkg::TOUCH_W-1:0]  blocks_touched,
    output logic [fcal_pkg::FREE_W-1:0]   free_left
);

    import fcal_pkg::*;

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int LINK_W = IDX_W + 1;
    localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
    localparam int PROD_W = CNT_W + BB_W;
    localparam int CMP_W  = (PROD_W > SIZE_W) ? PROD_W : SIZE_W;

    localparam logic [LINK_W-1:0] LINK_FREE = {LINK_W{1'b1}};
    localparam logic [LINK_W-1:0] LINK_END  = {{(LINK_W-1){1'b1}}, 1'b0};
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(NUM_BLOCKS - 1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [COV_W-1:0]  COV_BLOCK = COV_W'(BLOCK_BYTES);

    fcal_state_t state_reg, state_next;

    logic [START_W-1:0]  start_reg, start_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]    rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic                prev_dirty_reg, prev_dirty_next;
    logic [COV_W-1:0]    covered_reg, covered_next;
    logic [CNT_W-1:0]    taken_reg, taken_next;
    logic [CNT_W-1:0]    steps_reg, steps_next;
    logic [IDX_W-1:0]    term_reg, term_next;
    logic                term_ok_reg, term_ok_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [INDEX_W-1:0]  block_index_reg, block_index_next;
    logic [TOUCH_W-1:0]  blocks_touched_reg, blocks_touched_next;
    logic [FREE_W-1:0]   free_left_reg, free_left_next;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [LINK_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic [LINK_W-1:0]   mem_rdata;

    logic                in_fire;
    logic                start_ok;
    logic                too_large;
    logic                issue_more;
    logic                rd_is_free;
    logic                rd_end;
    logic [COV_W-1:0]    cov_add;
    logic                cov_reached;
    logic                link_free;
    logic                link_stop;
    logic                walk_last;
    logic [CNT_W-1:0]    fc_dec;
    logic [CNT_W-1:0]    fc_inc;
    logic                scan_state;

    // Link table storage.
    fcal_link_mem #(
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared conditions of the sequencer.
    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign start_ok   = 32'(chain_start) < NUM_BLOCKS;
    assign too_large  = CMP_W'(size_reg) > (CMP_W'(free_count_reg) * CMP_W'(BLOCK_BYTES));
    assign issue_more = issue_reg < CNT_FULL;
    // The last block linked still waits for its end mark, so it is not free.
    assign rd_is_free = rd_vld_reg && (mem_rdata == LINK_FREE)
                        && !(prev_dirty_reg && (rd_addr_reg == prev_reg));
    assign rd_end     = rd_vld_reg && (rd_addr_reg == IDX_LAST);
    assign cov_add    = covered_reg + COV_BLOCK;
    assign cov_reached = cov_add >= COV_W'(size_reg);
    assign link_free  = (mem_rdata == LINK_FREE);
    assign link_stop  = (mem_rdata >= LINK_W'(NUM_BLOCKS));
    assign walk_last  = (steps_reg == CNT_LAST);
    assign fc_dec     = (free_count_reg != '0) ? (free_count_reg - 1'b1) : free_count_reg;
    assign fc_inc     = (free_count_reg < CNT_FULL) ? (free_count_reg + 1'b1) : free_count_reg;
    assign scan_state = (state_reg == S_ALLOC) || (state_reg == S_EXT_SCAN)
                        || (state_reg == S_TERM_SCAN);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (issue_reg == CNT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (kind)
                        KIND_ALLOC:  state_next = S_ALLOC;
                        KIND_EXTEND: state_next = start_ok ? S_EXT_CHK : S_RESP;
                        KIND_FREE:   state_next = start_ok ? S_FREE_WALK : S_RESP;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (rd_is_free || rd_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_EXT_CHK:
            begin
                if (too_large)
                begin
                    state_next = S_RESP;
                end
                else if (COV_BLOCK < COV_W'(size_reg))
                begin
                    state_next = S_EXT_SCAN;
                end
                else
                begin
                    state_next = S_TERM_CHK;
                end
            end
            S_EXT_SCAN:
            begin
                if ((rd_is_free && cov_reached) || rd_end)
                begin
                    state_next = S_TERM_CHK;
                end
            end
            S_TERM_CHK:
            begin
                state_next = (free_count_reg != '0) ? S_TERM_SCAN : S_TERM_LINK;
            end
            S_TERM_SCAN:
            begin
                if (rd_is_free || rd_end)
                begin
                    state_next = S_TERM_LINK;
                end
            end
            S_TERM_LINK:
            begin
                state_next = term_ok_reg ? S_TERM_END : S_RESP;
            end
            S_TERM_END:
            begin
                state_next = S_RESP;
            end
            S_FREE_WALK:
            begin
                if (link_free || link_stop || walk_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, table accesses and result.
    always_comb
    begin
        start_next          = start_reg;
        size_next           = size_reg;
        free_count_next     = free_count_reg;
        issue_next          = issue_reg;
        rd_vld_next         = 1'b0;
        rd_addr_next        = rd_addr_reg;
        prev_next           = prev_reg;
        prev_dirty_next     = prev_dirty_reg;
        covered_next        = covered_reg;
        taken_next          = taken_reg;
        steps_next          = steps_reg;
        term_next           = term_reg;
        term_ok_next        = term_ok_reg;
        res_status_next     = res_status_reg;
        res_index_next      = res_index_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        status_next         = status_reg;
        block_index_next    = block_index_reg;
        blocks_touched_next = blocks_touched_reg;
        free_left_next      = free_left_reg;
        mem_we              = 1'b0;
        mem_waddr           = prev_reg;
        mem_wdata           = LINK_END;
        mem_re              = 1'b0;
        mem_raddr           = issue_reg[IDX_W-1:0];

        // First-fit scans issue one read per cycle and test the previous one.
        if (scan_state)
        begin
            mem_re       = issue_more;
            issue_next   = issue_more ? (issue_reg + 1'b1) : issue_reg;
            rd_vld_next  = issue_more && (state_next == state_reg);
            rd_addr_next = issue_reg[IDX_W-1:0];
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = issue_reg[IDX_W-1:0];
                mem_wdata  = LINK_FREE;
                issue_next = issue_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    start_next      = chain_start;
                    size_next       = size_bytes;
                    issue_next      = '0;
                    taken_next      = '0;
                    steps_next      = '0;
                    prev_dirty_next = 1'b0;
                    term_ok_next    = 1'b0;
                    prev_next       = IDX_W'(chain_start);
                    res_status_next = STATUS_OK;
                    res_index_next  = '0;
                    unique case (kind)
                        KIND_ALLOC:
                        begin
                            res_index_next = '0;
                        end
                        KIND_EXTEND:
                        begin
                            res_index_next  = INDEX_W'(chain_start);
                            res_status_next = start_ok ? STATUS_OK : STATUS_NO_FREE;
                        end
                        KIND_FREE:
                        begin
                            res_index_next  = INDEX_W'(chain_start);
                            res_status_next = start_ok ? STATUS_OK : STATUS_NO_FREE;
                            mem_re          = start_ok;
                            mem_raddr       = IDX_W'(chain_start);
                        end
                        default:
                        begin
                            res_index_next = '0;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (rd_is_free)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = rd_addr_reg;
                    mem_wdata       = LINK_END;
                    res_index_next  = INDEX_W'(rd_addr_reg);
                    res_status_next = STATUS_OK;
                end
                else if (rd_end)
                begin
                    res_index_next  = '0;
                    res_status_next = STATUS_NO_FREE;
                end
            end
            S_EXT_CHK:
            begin
                if (too_large)
                begin
                    res_status_next = STATUS_TOO_LARGE;
                end
                else
                begin
                    free_count_next = fc_dec;
                    covered_next    = COV_BLOCK;
                    taken_next      = CNT_W'(1);
                end
            end
            S_EXT_SCAN:
            begin
                // Link the found block behind the previous one; its own end
                // mark is deferred until the next link or the terminator.
                if (rd_is_free)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = prev_reg;
                    mem_wdata       = LINK_W'(rd_addr_reg);
                    prev_next       = rd_addr_reg;
                    prev_dirty_next = 1'b1;
                    taken_next      = taken_reg + 1'b1;
                    covered_next    = cov_add;
                    free_count_next = fc_dec;
                end
            end
            S_TERM_CHK:
            begin
                issue_next   = '0;
                term_ok_next = 1'b0;
            end
            S_TERM_SCAN:
            begin
                if (rd_is_free)
                begin
                    term_next    = rd_addr_reg;
                    term_ok_next = 1'b1;
                end
            end
            S_TERM_LINK:
            begin
                res_index_next = INDEX_W'(prev_reg);
                if (term_ok_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = prev_reg;
                    mem_wdata       = LINK_W'(term_reg);
                    res_status_next = STATUS_OK;
                end
                else
                begin
                    mem_we          = prev_dirty_reg;
                    mem_waddr       = prev_reg;
                    mem_wdata       = LINK_END;
                    res_status_next = STATUS_NO_TERM;
                end
            end
            S_TERM_END:
            begin
                mem_we    = 1'b1;
                mem_waddr = term_reg;
                mem_wdata = LINK_END;
            end
            S_FREE_WALK:
            begin
                // prev_reg holds the current block of the walk.
                res_index_next = INDEX_W'(prev_reg);
                if (!link_free)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = prev_reg;
                    mem_wdata  = LINK_FREE;
                    taken_next = taken_reg + 1'b1;
                    if (!link_stop)
                    begin
                        free_count_next = fc_inc;
                        prev_next       = mem_rdata[IDX_W-1:0];
                        steps_next      = steps_reg + 1'b1;
                        res_index_next  = INDEX_W'(mem_rdata[IDX_W-1:0]);
                        mem_re          = !walk_last;
                        mem_raddr       = mem_rdata[IDX_W-1:0];
                    end
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = res_status_reg;
                    block_index_next    = res_index_reg;
                    blocks_touched_next = TOUCH_W'(taken_reg);
                    free_left_next      = FREE_W'(free_count_reg);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            free_count_reg <= CNT_FULL;
            issue_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            prev_dirty_reg <= 1'b0;
            term_ok_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            issue_reg      <= issue_next;
            rd_vld_reg     <= rd_vld_next;
            prev_dirty_reg <= prev_dirty_next;
            term_ok_reg    <= term_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        start_reg          <= start_next;
        size_reg           <= size_next;
        rd_addr_reg        <= rd_addr_next;
        prev_reg           <= prev_next;
        covered_reg        <= covered_next;
        taken_reg          <= taken_next;
        steps_reg          <= steps_next;
        term_reg           <= term_next;
        res_status_reg     <= res_status_next;
        res_index_reg      <= res_index_next;
        status_reg         <= status_next;
        block_index_reg    <= block_index_next;
        blocks_touched_reg <= blocks_touched_next;
        free_left_reg      <= free_left_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign block_index    = block_index_reg;
    assign blocks_touched = blocks_touched_reg;
    assign free_left      = free_left_reg;

endmodule
